>>> design/itf_pkg.sv
// ----------------------------------------------------------------------------
// itf_pkg
// Shared types and constants for the integer text formatter.
// ----------------------------------------------------------------------------
package itf_pkg;

    localparam int MAX_FIELD_CHARS = 64;
    localparam int CNT_W = $clog2(MAX_FIELD_CHARS + 1);
    localparam int DIG_W = 7;
    localparam int IN_DATA_W = 88;
    localparam int BCD_W = 80;

    typedef enum logic [2:0]
    {
        CONV_D = 3'd0,
        CONV_U = 3'd1,
        CONV_X = 3'd2,
        CONV_XU = 3'd3,
        CONV_O = 3'd4,
        CONV_B = 3'd5,
        CONV_P = 3'd6,
        CONV_R = 3'd7
    } conv_t;

    // Classified request handed from the front to the back.
    typedef struct packed
    {
        logic [63:0] mag;
        logic [1:0] radix;       // 0 dec, 1 hex, 2 oct, 3 bin
        logic upper;
        logic is_nil;
        logic left;
        logic zpad;
        logic [1:0] pre_len;
        logic [7:0] pre0;
        logic [7:0] pre1;
        logic [CNT_W-1:0] width;
        logic [6:0] prec;        // saturated, valid when has_prec
        logic has_prec;
    } job_t;

    localparam logic [1:0] RAD_DEC = 2'd0;
    localparam logic [1:0] RAD_HEX = 2'd1;
    localparam logic [1:0] RAD_OCT = 2'd2;
    localparam logic [1:0] RAD_BIN = 2'd3;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        begin
            if (d < 4'd10)
                c = 8'h30 + {4'd0, d};
            else if (upper)
                c = 8'h37 + {4'd0, d};
            else
                c = 8'h57 + {4'd0, d};
            return c;
        end
    endfunction

    function automatic logic [7:0] nil_char(input logic [2:0] i);
        logic [7:0] c;
        begin
            case (i)
                3'd0: c = 8'h28;
                3'd1: c = 8'h6e;
                3'd2: c = 8'h69;
                3'd3: c = 8'h6c;
                default: c = 8'h29;
            endcase
            return c;
        end
    endfunction

endpackage

>>> design/itf_front.sv
// ----------------------------------------------------------------------------
// itf_front
// Decodes a request into magnitude, radix, prefix and padding controls.
// ----------------------------------------------------------------------------
module itf_front
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [itf_pkg::IN_DATA_W-1:0] in_data,
    output logic job_valid,
    input  logic job_ready,
    output itf_pkg::job_t job
);
    import itf_pkg::*;

    logic [63:0] value;
    logic wide;
    conv_t conv;
    logic left, plus, space, alt, zpad;
    logic [6:0] width_raw, prec_raw;
    logic [63:0] v, mag;
    logic sgn, neg, ptr;
    job_t j;
    logic valid_reg;
    job_t job_reg;

    always_comb
    begin
        value = in_data[63:0];
        wide = in_data[64];
        conv = conv_t'(in_data[67:65]);
        left = in_data[68];
        plus = in_data[69];
        space = in_data[70];
        alt = in_data[71];
        zpad = in_data[72];
        width_raw = in_data[79:73];
        prec_raw = in_data[86:80];
        ptr = (conv == CONV_P);
        sgn = (conv == CONV_D);
        v = (ptr || !wide) ? {32'd0, value[31:0]} : value;
        neg = sgn && (wide ? v[63] : v[31]);
        mag = v;
        if (neg)
            mag = wide ? (~v + 64'd1) : {32'd0, ~v[31:0] + 32'd1};
        j = '0;
        j.mag = mag;
        j.left = left;
        j.zpad = zpad && !left && prec_raw[6];
        j.has_prec = !prec_raw[6];
        j.prec = (prec_raw > 7'(MAX_FIELD_CHARS - 2)) ? 7'(MAX_FIELD_CHARS - 2) : prec_raw;
        j.width = (width_raw > 7'(MAX_FIELD_CHARS)) ? CNT_W'(MAX_FIELD_CHARS)
                                                    : CNT_W'(width_raw);
        j.is_nil = ptr && (v == 64'd0);
        unique case (conv)
            CONV_X, CONV_P: j.radix = RAD_HEX;
            CONV_XU: begin j.radix = RAD_HEX; j.upper = 1'b1; end
            CONV_O: j.radix = RAD_OCT;
            CONV_B: j.radix = RAD_BIN;
            default: j.radix = RAD_DEC;
        endcase
        if (j.is_nil)
        begin
            j.zpad = 1'b0;
            j.has_prec = 1'b0;
        end
        if (sgn && (neg || plus || space))
        begin
            j.pre_len = 2'd1;
            j.pre0 = neg ? 8'h2d : (plus ? 8'h2b : 8'h20);
        end
        else if ((alt || ptr) && j.radix == RAD_HEX && mag != 64'd0)
        begin
            j.pre_len = 2'd2;
            j.pre0 = 8'h30;
            j.pre1 = j.upper ? 8'h58 : 8'h78;
        end
        else if (alt && j.radix == RAD_OCT && mag != 64'd0)
        begin
            j.pre_len = 2'd1;
            j.pre0 = 8'h30;
        end
    end

    assign in_ready = !valid_reg || job_ready;
    assign job_valid = valid_reg;
    assign job = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            job_reg <= j;
    end
endmodule

>>> design/itf_back.sv
// ----------------------------------------------------------------------------
// itf_back
// Converts the magnitude to digits serially and streams the characters.
// ----------------------------------------------------------------------------
module itf_back
(
    input  logic clk,
    input  logic rst_n,
    input  logic job_valid,
    output logic job_ready,
    input  itf_pkg::job_t job,
    output logic out_valid,
    input  logic out_ready,
    output logic [7:0] out_char,
    output logic out_last
);
    import itf_pkg::*;

    typedef enum logic [4:0]
    {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_COUNT = 5'b00100,
        ST_PLAN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    job_t job_reg;
    logic [63:0] rem_reg;
    logic [BCD_W-1:0] digs_reg, scan_reg;
    logic [BCD_W-1:0] bcd_adj, digs_sh;
    logic [6:0] cnt_reg;
    logic [DIG_W-1:0] nd_reg;
    logic [CNT_W-1:0] pos_reg, total_reg;
    logic [CNT_W-1:0] lead_end_reg, pre_end_reg, zero_end_reg, dig_end_reg;
    logic [7:0] obuf_reg;
    logic olast_reg, ovalid_reg;
    logic [3:0] rdx;
    logic [3:0] dig;
    logic [6:0] mind, body;
    logic [6:0] pad, sp, zp;
    logic [7:0] ch;
    logic slot_free;
    logic [5:0] didx;
    logic [6:0] sh_amt;

    assign rdx = (job_reg.radix == RAD_OCT) ? 4'd7 :
                 (job_reg.radix == RAD_BIN) ? 4'd1 : 4'd15;
    assign slot_free = !ovalid_reg || out_ready;
    assign job_ready = (state_reg == ST_IDLE);
    assign out_valid = ovalid_reg;
    assign out_char = obuf_reg;
    assign out_last = olast_reg;

    always_comb
    begin
        for (int k = 0; k < BCD_W / 4; k++)
            bcd_adj[k*4 +: 4] = (digs_reg[k*4 +: 4] >= 4'd5) ? digs_reg[k*4 +: 4] + 4'd3
                                                             : digs_reg[k*4 +: 4];
        mind = (job_reg.has_prec && job_reg.prec > nd_reg) ? job_reg.prec : nd_reg;
        body = mind + {5'd0, job_reg.pre_len};
        if (job_reg.is_nil)
            body = 7'd5;
        pad = (7'(job_reg.width) > body) ? 7'(job_reg.width) - body : 7'd0;
        sp = (job_reg.left || job_reg.zpad) ? 7'd0 : pad;
        zp = job_reg.zpad ? pad : 7'd0;
        didx = 6'(dig_end_reg - pos_reg - 1'b1);
        unique case (job_reg.radix)
            RAD_OCT: sh_amt = {1'b0, didx} + {didx, 1'b0};
            RAD_BIN: sh_amt = {1'b0, didx};
            default: sh_amt = {didx[4:0], 2'b00};
        endcase
        digs_sh = digs_reg >> sh_amt;
        dig = digs_sh[3:0] & rdx;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (job_valid) state_next = ST_CONV;
            ST_CONV: if (cnt_reg == 7'd0) state_next = ST_COUNT;
            ST_COUNT: if (scan_reg == '0 && nd_reg != '0)
                          state_next = ST_PLAN;
            ST_PLAN: state_next = ST_EMIT;
            ST_EMIT: if (slot_free && pos_reg == total_reg - 1'b1)
                         state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        if (job_reg.is_nil)
            ch = (pos_reg >= lead_end_reg && pos_reg < pre_end_reg)
                 ? nil_char(3'(pos_reg - lead_end_reg)) : 8'h20;
        else if (pos_reg < lead_end_reg)
            ch = 8'h20;
        else if (pos_reg < pre_end_reg)
            ch = (pos_reg == lead_end_reg) ? job_reg.pre0 : job_reg.pre1;
        else if (pos_reg < zero_end_reg)
            ch = 8'h30;
        else if (pos_reg < dig_end_reg)
            ch = digit_char(dig, job_reg.upper);
        else
            ch = 8'h20;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EMIT && slot_free)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    // Decimal digits come from a 64-step shift-and-add-three pass; other
    // radixes read their digits straight from the magnitude. The digit count
    // is then found by shifting a copy right one digit per cycle.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                job_reg <= job;
                rem_reg <= job.mag;
                nd_reg <= '0;
                if (job.radix == RAD_DEC)
                begin
                    digs_reg <= '0;
                    cnt_reg <= 7'd64;
                end
                else
                begin
                    digs_reg <= {{(BCD_W - 64){1'b0}}, job.mag};
                    cnt_reg <= 7'd0;
                end
            end
            ST_CONV:
            begin
                if (cnt_reg != 7'd0)
                begin
                    digs_reg <= {bcd_adj[BCD_W-2:0], rem_reg[63]};
                    rem_reg <= {rem_reg[62:0], 1'b0};
                    cnt_reg <= cnt_reg - 7'd1;
                end
                else
                    scan_reg <= digs_reg;
            end
            ST_COUNT:
            begin
                if (scan_reg != '0 || nd_reg == '0)
                begin
                    nd_reg <= nd_reg + 1'b1;
                    unique case (job_reg.radix)
                        RAD_OCT: scan_reg <= scan_reg >> 3;
                        RAD_BIN: scan_reg <= scan_reg >> 1;
                        default: scan_reg <= scan_reg >> 4;
                    endcase
                end
            end
            ST_PLAN:
            begin
                pos_reg <= '0;
                lead_end_reg <= CNT_W'(sp);
                pre_end_reg <= CNT_W'(sp)
                               + (job_reg.is_nil ? CNT_W'(5) : CNT_W'(job_reg.pre_len));
                zero_end_reg <= CNT_W'(sp) + CNT_W'(job_reg.pre_len) + CNT_W'(zp)
                                + CNT_W'(mind - nd_reg);
                dig_end_reg <= CNT_W'(sp) + CNT_W'(zp) + CNT_W'(body);
                total_reg <= CNT_W'(pad) + CNT_W'(body);
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    obuf_reg <= ch;
                    olast_reg <= (pos_reg == total_reg - 1'b1);
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule

>>> design/integer_text_formatter.sv
// ----------------------------------------------------------------------------
// integer_text_formatter
// Formats one printf-style integer conversion into a stream of characters.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata                                              tuser
// s_axis   in   value, wide_value, conversion, flags, width, prec  -
// m_axis   out  character                                          - (tlast = last)
// The front decodes a request into a one-entry queue.
// The back takes the job, runs the shift-and-add-three pass for decimal
// (other radixes skip it), counts the digits one per cycle, plans the
// field, then sends one output character per cycle unless the output stalls.
// Reset clears the control state only.
// Either side may stall; the queue lets the front accept while the back works.
module integer_text_formatter
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // value[63:0], wide_value[64], conversion[67:65], minus_flag[68],
    // plus_flag[69], blank_flag[70], hash_flag[71], zero_flag[72],
    // field_width[79:73], min_digits[86:80], bit 87 unused
    input  logic [87:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // character[7:0]
    output logic [7:0] m_axis_tdata,
    output logic m_axis_tlast
);
    import itf_pkg::*;

    logic job_valid, job_ready;
    job_t job;

    itf_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    itf_back u_back
    (
        .clk(clk), .rst_n(rst_n),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_char(m_axis_tdata), .out_last(m_axis_tlast)
    );
endmodule
